>>> src/kess_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Keypad entry package
// Shared widths, the key report type and the hex to seven-segment encoding.
// ---------------------------------------------------------------------------
package kess_pkg;

    localparam int unsigned KEYS_W      = 16;
    localparam int unsigned KEY_W       = 4;
    localparam int unsigned SEG_W       = 8;
    localparam int unsigned DEB_W       = 8;
    localparam int unsigned STORE_DEPTH = 8;
    localparam int unsigned POS_W       = 3;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

    // One reported key, travelling from the key machine to the digit store.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] code;
    } t_key_report;

    // Hex digit to segment pattern, bit 0 is segment a, bit 7 the point.
    function automatic logic [SEG_W-1:0] hex_to_seg(input logic [KEY_W-1:0] hex);
        logic [SEG_W-1:0] seg;
        unique case (hex)
            4'h0: seg = 8'h3f;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5b;
            4'h3: seg = 8'h4f;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6d;
            4'h6: seg = 8'h7d;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7f;
            4'h9: seg = 8'h6f;
            4'ha: seg = 8'h77;
            4'hb: seg = 8'h7c;
            4'hc: seg = 8'h39;
            4'hd: seg = 8'h5e;
            4'he: seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

>>> src/kess_key_fsm.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Keypad scan state machine
// Debounces a press, picks the key on the first active drive line, waits for
// that line to release, debounces the release and reports the key when only one key on the line was closed.
// ---------------------------------------------------------------------------
module kess_key_fsm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire logic [kess_pkg::KEYS_W-1:0] i_key_pressed,
    input  wire logic [kess_pkg::DEB_W-1:0]  i_debounce_ticks,
    output kess_pkg::t_key_report            o_report
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PRESS_DEB = 3'd1;
    localparam logic [2:0] PH_REL_WAIT  = 3'd2;
    localparam logic [2:0] PH_REL_DEB   = 3'd3;
    localparam logic [2:0] PH_REL_HOLD  = 3'd4;

    // Sense bits of one drive line, bit s for sense line s.
    function automatic logic [3:0] line_of(input logic [kess_pkg::KEYS_W-1:0] keys,
                                           input logic [1:0] drive);
        logic [3:0] bits;
        for (int s = 0; s < 4; s++) begin
            bits[s] = keys[{s[1:0], drive}];
        end
        return bits;
    endfunction

    logic [2:0]                      r_phase, n_phase;
    logic [kess_pkg::DEB_W-1:0]      r_count, n_count;
    logic [kess_pkg::KEY_W-1:0]      r_held_key, n_held_key;
    logic [1:0]                      r_held_line, n_held_line;
    logic                            r_held_ok, n_held_ok;

    logic       fire;
    logic       held_clear;
    logic       any_key;
    logic [1:0] scan_line;
    logic [3:0] scan_bits;
    logic [1:0] scan_which;
    logic [2:0] scan_count;

    assign held_clear = (line_of(i_key_pressed, r_held_line) == 4'd0);
    assign any_key    = (i_key_pressed != '0);

    // First drive line with a closed key, and the highest closed sense line on it.
    always_comb begin
        scan_line  = 2'd0;
        scan_bits  = 4'd0;
        scan_which = 2'd0;
        scan_count = 3'd0;
        for (int d = 3; d >= 0; d--) begin
            if (line_of(i_key_pressed, d[1:0]) != 4'd0) begin
                scan_line = d[1:0];
                scan_bits = line_of(i_key_pressed, d[1:0]);
            end
        end
        for (int s = 0; s < 4; s++) begin
            if (scan_bits[s]) begin
                scan_which = s[1:0];
                scan_count = scan_count + 3'd1;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_held_key  = r_held_key;
        n_held_line = r_held_line;
        n_held_ok   = r_held_ok;
        fire        = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (any_key) begin
                    n_count = '0;
                    n_phase = PH_PRESS_DEB;
                end
            end
            PH_PRESS_DEB: begin
                if (r_count < i_debounce_ticks) begin
                    n_count = r_count + 1'b1;
                end else if (!any_key) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_held_line = scan_line;
                    n_held_ok   = (scan_count == 3'd1);
                    // Key value is drive + 4 * (3 - sense).
                    n_held_key  = (scan_count == 3'd1) ? {~scan_which, scan_line} : '0;
                    n_phase     = PH_REL_WAIT;
                end
            end
            PH_REL_WAIT: begin
                if (held_clear) begin
                    n_count = '0;
                    n_phase = PH_REL_DEB;
                end
            end
            PH_REL_DEB: begin
                if (r_count < i_debounce_ticks) begin
                    n_count = r_count + 1'b1;
                end else if (held_clear) begin
                    fire = 1'b1;
                end else begin
                    n_phase = PH_REL_HOLD;
                end
            end
            PH_REL_HOLD: begin
                if (held_clear) begin
                    fire = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (fire) begin
            n_phase = PH_IDLE;
        end
    end

    assign o_report.valid = fire && r_held_ok;
    assign o_report.code  = (fire && r_held_ok) ? r_held_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_held_key  <= '0;
            r_held_line <= '0;
            r_held_ok   <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_held_key  <= n_held_key;
            r_held_line <= n_held_line;
            r_held_ok   <= n_held_ok;
        end
    end

    // A key is only ever reported from one of the release phases.
    a_report_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report.valid |-> (r_phase == PH_REL_DEB || r_phase == PH_REL_HOLD))
        else $error("key reported outside a release phase");

    // A report that is taken sends the machine back to idle.
    a_report_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_report.valid && i_advance) |=> (r_phase == PH_IDLE))
        else $error("machine not idle after a report");

    // An invalid press never produces a report.
    a_invalid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_ok |-> !o_report.valid)
        else $error("invalid press was reported");

endmodule
`default_nettype wire

>>> src/kess_digit_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Digit store and display multiplexer
// Shifts reported keys into an eight digit store and selects one digit a tick.
// ---------------------------------------------------------------------------
module kess_digit_store #(
    parameter int unsigned DIGITS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire kess_pkg::t_key_report      i_report,
    output logic [kess_pkg::SEG_W-1:0]      o_digit_enable_n,
    output logic [kess_pkg::SEG_W-1:0]      o_segment_bits
);

    localparam logic [3:0] DIGITS_C = 4'(DIGITS);
    localparam logic [3:0] FULL     = 4'(kess_pkg::STORE_DEPTH);

    logic [kess_pkg::SEG_W-1:0] r_store [kess_pkg::STORE_DEPTH];
    logic [kess_pkg::SEG_W-1:0] n_store [kess_pkg::STORE_DEPTH];
    logic [3:0]                 r_count, n_count;
    logic [kess_pkg::POS_W-1:0] r_pos, n_pos;
    logic [kess_pkg::POS_W-1:0] pos;
    logic [3:0]                 pos_inc;

    always_comb begin
        n_store = r_store;
        n_count = r_count;
        if (i_report.valid) begin
            if (r_count < FULL) begin
                for (int i = 0; i < kess_pkg::STORE_DEPTH - 1; i++) begin
                    n_store[i] = r_store[i + 1];
                end
                n_store[kess_pkg::STORE_DEPTH - 1] = kess_pkg::hex_to_seg(i_report.code);
            end
            n_count = r_count + 4'd1;
            // The ninth key clears the entry.
            if (n_count > FULL) begin
                n_count = '0;
                for (int i = 0; i < kess_pkg::STORE_DEPTH; i++) begin
                    n_store[i] = '0;
                end
            end
        end
    end

    assign pos     = ({1'b0, r_pos} >= DIGITS_C) ? '0 : r_pos;
    assign pos_inc = {1'b0, pos} + 4'd1;
    assign n_pos   = (pos_inc >= DIGITS_C) ? '0 : pos_inc[kess_pkg::POS_W-1:0];

    assign o_digit_enable_n = ~(kess_pkg::SEG_W'(1) << pos);
    assign o_segment_bits   = n_store[pos];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kess_pkg::STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_advance) begin
            r_store <= n_store;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    // The entry count never passes a full store.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count beyond store depth");

    // Exactly one digit is enabled.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(~o_digit_enable_n))
        else $error("digit enable not one-hot");

    // The shown position stays inside the configured digit count.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < DIGITS_C)
        else $error("display position out of range");

endmodule
`default_nettype wire

>>> src/keypad_entry_seven_segment_scan_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Keypad entry with seven-segment scan, top level
// 4x4 keypad scanner feeding an eight digit hex entry and a multiplexed
// seven-segment display, one scan tick per input beat.
// ---------------------------------------------------------------------------
// Each input beat is one scan tick carrying a snapshot of the key matrix, and
// each tick yields exactly one output beat: the active-low enable and segment
// byte of one display digit, plus a key report. An input register holds the
// snapshot, short logic runs the key machine and the digit store, and the
// output register holds the result, so the block takes one beat every clock
// while the output side keeps taking beats. The output register lets a new
// beat enter while a finished one still waits. The debounce register is
// written on its own channel, which is always ready; write it only while no
// tick is in flight. DIGITS sets how many positions are scanned; the store
// always holds eight digits.
// ---------------------------------------------------------------------------
module keypad_entry_seven_segment_scan_top #(
    parameter int unsigned DIGITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration channel
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [kess_pkg::DEB_W-1:0]  i_debounce_ticks,
    // Input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [kess_pkg::KEYS_W-1:0] i_key_pressed,
    // Output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [kess_pkg::SEG_W-1:0]       o_digit_enable_n,
    output logic [kess_pkg::SEG_W-1:0]       o_segment_bits,
    output logic                             o_key_valid,
    output logic [kess_pkg::KEY_W-1:0]       o_key_code
);

    logic [kess_pkg::DEB_W-1:0]  r_debounce_ticks;

    // Input register.
    logic                        r_in_valid;
    logic [kess_pkg::KEYS_W-1:0] r_key_pressed;

    // Output register.
    logic                        r_out_valid;
    logic [kess_pkg::SEG_W-1:0]  r_digit_enable_n;
    logic [kess_pkg::SEG_W-1:0]  r_segment_bits;
    logic                        r_key_valid;
    logic [kess_pkg::KEY_W-1:0]  r_key_code;

    logic                        advance;
    kess_pkg::t_key_report       report;
    logic [kess_pkg::SEG_W-1:0]  digit_enable_n;
    logic [kess_pkg::SEG_W-1:0]  segment_bits;

    // The tick in the input register moves on whenever the output register is
    // free or is being emptied in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= kess_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce_ticks <= i_debounce_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_key_pressed <= i_key_pressed;
        end
    end

    kess_key_fsm u_key_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_key_pressed    (r_key_pressed),
        .i_debounce_ticks (r_debounce_ticks),
        .o_report         (report)
    );

    kess_digit_store #(
        .DIGITS (DIGITS)
    ) u_digit_store (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_report         (report),
        .o_digit_enable_n (digit_enable_n),
        .o_segment_bits   (segment_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_digit_enable_n <= digit_enable_n;
            r_segment_bits   <= segment_bits;
            r_key_valid      <= report.valid;
            r_key_code       <= report.code;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_digit_enable_n = r_digit_enable_n;
    assign o_segment_bits   = r_segment_bits;
    assign o_key_valid      = r_key_valid;
    assign o_key_code       = r_key_code;

    // A tick only moves on when there is one in the input register.
    a_advance_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> r_in_valid)
        else $error("advance without a held tick");

    // A beat that moves on always lands in the output register.
    a_advance_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("output register empty after advance");

    // A shown key code is zero unless a key is reported.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_key_valid) |-> (r_key_code == '0))
        else $error("key code set without a report");

endmodule
`default_nettype wire
